// ----- sv/mft_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mft_pkg
// Shared types and constants for the Manchester frame transmitter.
// ----------------------------------------------------------------------------
package mft_pkg;

	localparam int TIMER_WIDTH_DEF = 16;
	localparam int QUEUE_DEPTH     = 4;

	localparam int S_DATA_W   = 16;
	localparam int M_DATA_W   = 8;
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 16;

	localparam logic [CFG_IDX_W-1:0] CFG_HALF_BIT_CYCLES = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_SYNC_PAIRS      = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_START_PATTERN   = 2'd2;

	localparam logic [15:0] HALF_BIT_CYCLES_RST = 16'd1000;
	localparam logic [5:0]  SYNC_PAIRS_RST      = 6'd32;
	localparam logic [7:0]  START_PATTERN_RST   = 8'h00;

	typedef struct packed {
		logic [15:0] half_bit_cycles;
		logic [5:0]  sync_pairs;
		logic [7:0]  start_pattern;
	} cfg_t;

	typedef struct packed {
		logic       load;
		logic [7:0] data_byte;
	} item_t;

endpackage

// ----- sv/mft_front.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mft_front
// Input register: accepts beats, splits out the load request and payload.
// ----------------------------------------------------------------------------
module mft_front import mft_pkg::*; (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                s_tvalid,
	output logic                s_tready,
	input  logic [S_DATA_W-1:0] s_tdata,   // [0] load, [8:1] data_byte, [15:9] zero
	output logic                push_valid,
	input  logic                push_ready,
	output item_t               push_item
);

	logic  valid_s1;
	item_t item_s1;
	logic  accept;

	assign s_tready   = !valid_s1 || push_ready;
	assign accept     = s_tvalid && s_tready;
	assign push_valid = valid_s1;
	assign push_item  = item_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (accept) begin
			valid_s1 <= 1'b1;
		end else if (push_ready) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			item_s1.load      <= s_tdata[0];
			item_s1.data_byte <= s_tdata[8:1];
		end
	end

endmodule

// ----- sv/mft_queue.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mft_queue
// Small FIFO between the input register and the line engine.
// ----------------------------------------------------------------------------
module mft_queue import mft_pkg::*; (
	input  logic  clk,
	input  logic  arst_n,
	input  logic  push_valid,
	output logic  push_ready,
	input  item_t push_item,
	output logic  pop_valid,
	input  logic  pop_ready,
	output item_t pop_item
);

	localparam int PTR_W = $clog2(QUEUE_DEPTH);
	localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

	item_t            mem_q [QUEUE_DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] count_q;
	logic             do_push;
	logic             do_pop;

	assign push_ready = count_q != CNT_W'(QUEUE_DEPTH);
	assign pop_valid  = count_q != '0;
	assign pop_item   = mem_q[rd_ptr_q];
	assign do_push    = push_valid && push_ready;
	assign do_pop     = pop_valid && pop_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + PTR_W'(1);
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + PTR_W'(1);
			end
			unique case ({do_push, do_pop})
				2'b10:   count_q <= count_q + CNT_W'(1);
				2'b01:   count_q <= count_q - CNT_W'(1);
				default: count_q <= count_q;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= push_item;
		end
	end

endmodule

// ----- sv/mft_back.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mft_back
// Line engine: runs the sync preamble and shifted Manchester bits per beat.
// ----------------------------------------------------------------------------
module mft_back import mft_pkg::*; #(
	parameter int TIMER_WIDTH = TIMER_WIDTH_DEF
) (
	input  logic                clk,
	input  logic                arst_n,
	input  cfg_t                cfg,
	input  logic                pop_valid,
	output logic                pop_ready,
	input  item_t               pop_item,
	output logic                m_tvalid,
	input  logic                m_tready,
	output logic [M_DATA_W-1:0] m_tdata    // [0] line, [1] busy_res, [7:2] zero
);

	localparam int HW = ((TIMER_WIDTH > 16) ? TIMER_WIDTH : 16) + 1;

	typedef enum logic [1:0] {
		ST_IDLE = 2'd0,
		ST_SYNC = 2'd1,
		ST_BITS = 2'd2
	} stage_t;

	stage_t                 stage_q;
	logic [TIMER_WIDTH-1:0] timer_q;
	logic [5:0]             sync_count_q;
	logic [3:0]             bit_pos_q;
	logic [1:0]             half_phase_q;
	logic [15:0]            frame_bits_q;
	logic                   line_level_q;
	logic                   out_valid_q;
	logic                   out_line_q;
	logic                   out_busy_q;

	logic [HW-1:0] hbc_ext;
	logic [HW-1:0] lim;
	logic [HW-1:0] half_len;
	logic [HW-1:0] timer_inc;
	logic          terminal;
	logic [6:0]    pairs;
	logic          cur_bit;
	logic          line_c;
	logic          busy_c;
	logic          step;

	assign hbc_ext   = HW'(cfg.half_bit_cycles);
	assign lim       = HW'(1) << TIMER_WIDTH;
	assign half_len  = (hbc_ext == '0) ? HW'(1) : ((hbc_ext > lim) ? lim : hbc_ext);
	assign timer_inc = HW'(timer_q) + HW'(1);
	assign terminal  = timer_inc >= half_len;
	assign pairs     = (cfg.sync_pairs == '0) ? 7'd1 : {1'b0, cfg.sync_pairs};
	assign cur_bit   = frame_bits_q[bit_pos_q];

	always_comb begin
		unique case (stage_q)
			ST_SYNC: begin
				line_c = !half_phase_q[1];
				busy_c = 1'b1;
			end
			ST_BITS: begin
				line_c = (half_phase_q == 2'd0) ? line_level_q : !cur_bit;
				busy_c = 1'b1;
			end
			default: begin
				line_c = line_level_q;
				busy_c = 1'b0;
			end
		endcase
	end

	assign pop_ready = !out_valid_q || m_tready;
	assign step      = pop_valid && pop_ready;
	assign m_tvalid  = out_valid_q;
	assign m_tdata   = {{(M_DATA_W - 2){1'b0}}, out_busy_q, out_line_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			stage_q      <= ST_IDLE;
			timer_q      <= '0;
			sync_count_q <= '0;
			bit_pos_q    <= '0;
			half_phase_q <= '0;
			frame_bits_q <= '0;
			line_level_q <= 1'b0;
			out_valid_q  <= 1'b0;
			out_line_q   <= 1'b0;
			out_busy_q   <= 1'b0;
		end else if (step) begin
			out_valid_q <= 1'b1;
			out_line_q  <= line_c;
			out_busy_q  <= busy_c;
			if (stage_q != ST_SYNC && stage_q != ST_BITS) begin
				stage_q <= ST_IDLE;
				if (pop_item.load) begin
					stage_q      <= ST_SYNC;
					timer_q      <= '0;
					sync_count_q <= '0;
					half_phase_q <= '0;
					bit_pos_q    <= '0;
					frame_bits_q <= {pop_item.data_byte, cfg.start_pattern};
				end
			end else if (!terminal) begin
				timer_q <= timer_q + TIMER_WIDTH'(1);
			end else begin
				timer_q <= '0;
				if (stage_q == ST_SYNC) begin
					if (half_phase_q == 2'd3) begin
						half_phase_q <= '0;
						if ({1'b0, sync_count_q} + 7'd1 >= pairs) begin
							stage_q      <= ST_BITS;
							line_level_q <= 1'b1;
							bit_pos_q    <= '0;
							sync_count_q <= '0;
						end else begin
							sync_count_q <= sync_count_q + 6'd1;
						end
					end else begin
						half_phase_q <= half_phase_q + 2'd1;
					end
				end else if (half_phase_q == 2'd0) begin
					half_phase_q <= 2'd1;
				end else begin
					half_phase_q <= '0;
					line_level_q <= cur_bit;
					if (bit_pos_q == 4'd15) begin
						stage_q   <= ST_IDLE;
						bit_pos_q <= '0;
					end else begin
						bit_pos_q <= bit_pos_q + 4'd1;
					end
				end
			end
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

`ifndef SYNTH
	a_bits_half: assert property (@(posedge clk) disable iff (!arst_n)
		stage_q == ST_BITS |-> half_phase_q[1] == 1'b0)
		else $error("half phase out of range in bit stage");
	a_timer_bound: assert property (@(posedge clk) disable iff (!arst_n)
		stage_q != ST_IDLE |-> HW'(timer_q) < half_len)
		else $error("tick timer passed half bit length");
	a_sync_bound: assert property (@(posedge clk) disable iff (!arst_n)
		stage_q == ST_SYNC |-> {1'b0, sync_count_q} < pairs)
		else $error("sync count passed pair count");
	a_busy_out: assert property (@(posedge clk) disable iff (!arst_n)
		step && stage_q == ST_IDLE |=> out_busy_q == 1'b0)
		else $error("busy shown for idle beat");
`endif

endmodule

// ----- sv/manchester_frame_transmitter.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// manchester_frame_transmitter
// Timer-driven Manchester frame serializer with sync preamble.
// ----------------------------------------------------------------------------
// Each input beat is one tick of the line clock and yields exactly one output
// beat holding the line level and busy flag for that tick. One beat is taken
// per cycle while the queue and the output side do not stall; a beat passes
// the input register, a four-entry queue and the line engine, and is
// registered in each of them in turn before its result is presented. The
// engine updates its state once per beat, which sets the rate of one beat per
// clock when the output side does not stall.
module manchester_frame_transmitter import mft_pkg::*; #(
	parameter int TIMER_WIDTH = TIMER_WIDTH_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data,
	input  logic                  s_tvalid,
	output logic                  s_tready,
	input  logic [S_DATA_W-1:0]   s_tdata,   // [0] load, [8:1] data_byte, [15:9] zero
	output logic                  m_tvalid,
	input  logic                  m_tready,
	output logic [M_DATA_W-1:0]   m_tdata    // [0] line, [1] busy_res, [7:2] zero
);

	cfg_t  cfg_q;
	logic  push_valid;
	logic  push_ready;
	item_t push_item;
	logic  pop_valid;
	logic  pop_ready;
	item_t pop_item;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.half_bit_cycles <= HALF_BIT_CYCLES_RST;
			cfg_q.sync_pairs      <= SYNC_PAIRS_RST;
			cfg_q.start_pattern   <= START_PATTERN_RST;
		end else if (cfg_we) begin
			unique case (cfg_index)
				CFG_HALF_BIT_CYCLES: cfg_q.half_bit_cycles <= cfg_data;
				CFG_SYNC_PAIRS:      cfg_q.sync_pairs      <= cfg_data[5:0];
				CFG_START_PATTERN:   cfg_q.start_pattern   <= cfg_data[7:0];
				default:             cfg_q                 <= cfg_q;
			endcase
		end
	end

	mft_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.s_tvalid   (s_tvalid),
		.s_tready   (s_tready),
		.s_tdata    (s_tdata),
		.push_valid (push_valid),
		.push_ready (push_ready),
		.push_item  (push_item)
	);

	mft_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_valid (push_valid),
		.push_ready (push_ready),
		.push_item  (push_item),
		.pop_valid  (pop_valid),
		.pop_ready  (pop_ready),
		.pop_item   (pop_item)
	);

	mft_back #(
		.TIMER_WIDTH (TIMER_WIDTH)
	) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg_q),
		.pop_valid (pop_valid),
		.pop_ready (pop_ready),
		.pop_item  (pop_item),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata)
	);

endmodule
